// ===== sv/stirl_pkg.sv =====
package stirl_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int VALUE_W       = 16;
    localparam int CFG_W         = 5;
    localparam int OUT_TDATA_W   = 8;
    localparam int MODE_W        = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_SORTED = 2'd3
    } t_mode;

endpackage

// ===== sv/stirl_ram.sv =====
module stirl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/sentinel_table_insert_remove_lookup_unit.sv =====
// Small table of DEPTH 16-bit slots, empty after reset, with four operations picked by the
// mode in tuser: insert into the first empty slot (table_full if none), remove the first
// matching value and close the gap, lookup, and sorted insert (placed before the first larger
// entry, empties count as smaller, the last covered entry falls off). Only the first
// min(entries_in_use, DEPTH) slots take part; entries_in_use is written through the cfg port
// by the user only while the block is idle; the block itself does not enforce this. The
// values sit in one single-port-write RAM, and an empty slot is a cleared valid flop, so
// reset needs no clearing pass. Every operation is one pass of a shared read/compare/write
// unit over the covered slots, one slot per cycle. The next item is accepted in the cycle
// after the result is loaded, so no new item is taken before the last one is through. Each
// item passes through the scan of the covered slots, the registered RAM read, a drain of the
// last read and the loading of the result; a result beat that is still waiting on
// o_m_tready holds the finish step back further.
module sentinel_table_insert_remove_lookup_unit #(
    parameter int DEPTH = stirl_pkg::DEFAULT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cfg write channel: entries_in_use
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stirl_pkg::CFG_W-1:0]      i_cfg_data,
    // input beats
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [stirl_pkg::VALUE_W-1:0]    i_s_tdata,   // [15:0] value
    input  logic [stirl_pkg::MODE_W-1:0]     i_s_tuser,   // [1:0] mode
    // result beats
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [stirl_pkg::OUT_TDATA_W-1:0] o_m_tdata   // [0] found, [1] table_full, rest 0
);

    import stirl_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cfg;
    t_mode              r_mode;
    logic [VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]   r_n;        // covered slots for this item
    logic [CNT_W-1:0]   r_rd;       // next slot to read
    logic               r_rv;       // read data in flight is valid
    logic [AW-1:0]      r_ri;       // slot of the data coming back
    logic               r_hit;      // match found or value placed
    logic [VALUE_W-1:0] r_carry_d;  // entry pushed right by sorted insert
    logic               r_carry_v;
    logic [DEPTH-1:0]   r_valid;    // cleared bit = empty slot
    logic               r_ov;
    logic               r_found;
    logic               r_full;

    logic               n_hit;
    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic [VALUE_W-1:0] w_data;
    logic               w_vbit;
    logic               carry_ld;
    logic [VALUE_W-1:0] rd_data;
    logic               rd_vld;
    logic               issue;
    logic               eq_hit;
    logic               gt_hit;
    logic               out_free;
    logic               res_load;
    logic [CMP_W-1:0]   cfg_ext;
    logic [CMP_W-1:0]   cov;
    logic [CNT_W-1:0]   last_idx;

    // coverage saturates at the table depth
    assign cfg_ext = CMP_W'(r_cfg);
    assign cov     = (cfg_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cfg_ext;

    assign issue    = (r_state == S_SCAN) && (r_rd < r_n);
    assign rd_vld   = r_valid[r_ri];
    assign eq_hit   = rd_vld && (rd_data == r_val);
    assign gt_hit   = rd_vld && (r_val < rd_data);   // empty never larger
    assign out_free = !r_ov || i_m_tready;
    assign res_load = (r_state == S_FINISH) && out_free;
    assign last_idx = r_n - 1'b1;

    stirl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_en),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (rd_data)
    );

    // per-slot action on each returning read
    always_comb begin
        n_hit    = r_hit;
        w_en     = 1'b0;
        w_addr   = r_ri;
        w_data   = r_val;
        w_vbit   = 1'b1;
        carry_ld = 1'b0;
        if (r_rv) begin
            unique case (r_mode)
                MODE_INSERT: begin
                    if (!r_hit && !rd_vld) begin
                        w_en  = 1'b1;
                        n_hit = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (r_hit) begin
                        // slide later entries one slot left
                        w_en   = 1'b1;
                        w_addr = r_ri - 1'b1;
                        w_data = rd_data;
                        w_vbit = rd_vld;
                    end else if (eq_hit) begin
                        n_hit = 1'b1;
                    end
                end
                MODE_LOOKUP: begin
                    if (eq_hit) begin
                        n_hit = 1'b1;
                    end
                end
                MODE_SORTED: begin
                    if (r_hit) begin
                        // ripple the carried entry one slot right
                        w_en     = 1'b1;
                        w_data   = r_carry_d;
                        w_vbit   = r_carry_v;
                        carry_ld = 1'b1;
                    end else if (gt_hit) begin
                        w_en     = 1'b1;
                        n_hit    = 1'b1;
                        carry_ld = 1'b1;
                    end
                end
                default: begin
                    n_hit = r_hit;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = {{(OUT_TDATA_W - 2){1'b0}}, r_full, r_found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_RESET;
            r_valid <= '0;
            r_rv    <= 1'b0;
            r_hit   <= 1'b0;
            r_ov    <= 1'b0;
            r_rd    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            // a new result may replace the one leaving in the same cycle
            if (res_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (w_en) begin
                r_valid[w_addr] <= w_vbit;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_mode  <= t_mode'(i_s_tuser);
                        r_val   <= i_s_tdata;
                        r_n     <= CNT_W'(cov);
                        r_rd    <= '0;
                        r_rv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_hit <= n_hit;
                    r_rv  <= issue;
                    r_ri  <= r_rd[AW-1:0];
                    if (issue) begin
                        r_rd <= r_rd + 1'b1;
                    end else if (!r_rv) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_found <= r_hit && ((r_mode == MODE_REMOVE) ||
                                             (r_mode == MODE_LOOKUP));
                        r_full  <= (r_mode == MODE_INSERT) && !r_hit;
                        // removal leaves the last covered slot empty
                        if ((r_mode == MODE_REMOVE) && r_hit) begin
                            r_valid[last_idx[AW-1:0]] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (carry_ld) begin
            r_carry_d <= rd_data;
            r_carry_v <= rd_vld;
        end
    end

endmodule
